FILE: rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, constants, types and helper functions for the quaternion
// to Y-X-Z Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CORDIC_STAGES = 16;           // 8..24
  localparam int ATAN_LEN      = 24;

  localparam int QW   = 16;                    // quaternion component width
  localparam int PW   = 2 * QW;                // product width
  localparam int MW   = PW + 2;                // matrix term width
  localparam int SW   = 32;                    // clamped arcsine argument
  localparam int VW   = 61;                    // radicand width (<= 2^60)
  localparam int RW   = 31;                    // square root width (<= 2^30)
  localparam int CW   = MW + 3;                // CORDIC x/y width
  localparam int ZW   = 26;                    // angle width, 2^-16 degree
  localparam int IW   = 5;                     // stage index width
  localparam int AW   = 16;                    // Q9.7 output width
  localparam int PAW  = 15;                    // Q8.7 pitch width

  localparam int SQRT_BITS = RW;
  localparam int SQRT_DLY  = 2 + SQRT_BITS;    // s^2, radicand, root bits
  localparam int LAT       = 4 + SQRT_BITS + 1 + CORDIC_STAGES + 1;

  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
  localparam logic signed [MW-1:0] ONE_Q30 = MW'(64'sd1 << 30);
  localparam logic signed [AW-1:0] YAW_LIMIT   = AW'(23040);
  localparam logic signed [AW-1:0] PITCH_LIMIT = AW'(11520);

  typedef struct packed {
    logic signed [MW-1:0] m02;
    logic signed [MW-1:0] m22;
    logic signed [MW-1:0] m10;
    logic signed [MW-1:0] m11;
    logic signed [SW-1:0] s;
  } m_terms_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 hold;
  } rot_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ZW-1:0] atan_lut(input logic [IW-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = ZW'(2949120);
      5'd1:  r = ZW'(1740967);
      5'd2:  r = ZW'(919879);
      5'd3:  r = ZW'(466945);
      5'd4:  r = ZW'(234379);
      5'd5:  r = ZW'(117304);
      5'd6:  r = ZW'(58666);
      5'd7:  r = ZW'(29335);
      5'd8:  r = ZW'(14668);
      5'd9:  r = ZW'(7334);
      5'd10: r = ZW'(3667);
      5'd11: r = ZW'(1833);
      5'd12: r = ZW'(917);
      5'd13: r = ZW'(458);
      5'd14: r = ZW'(229);
      5'd15: r = ZW'(115);
      5'd16: r = ZW'(57);
      5'd17: r = ZW'(29);
      5'd18: r = ZW'(14);
      5'd19: r = ZW'(7);
      5'd20: r = ZW'(4);
      5'd21: r = ZW'(2);
      5'd22: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // round 2^-16 degree to Q9.7 (half up) and saturate to +/- limit
  function automatic logic signed [AW-1:0] round_angle(input logic signed [ZW-1:0] a,
                                                       input logic signed [AW-1:0] limit);
    logic signed [ZW-1:0]   t;
    logic signed [ZW-10:0]  r;
    logic signed [ZW-10:0]  lim;
    t   = a + ZW'(256);
    r   = (ZW-9)'(t >>> 9);
    lim = (ZW-9)'(limit);
    if (r > lim)       r = lim;
    else if (r < -lim) r = -lim;
    return AW'(r);
  endfunction

endpackage

FILE: rtl/q2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One restoring square-root digit: decides root bit k, registers result.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [q2e_pkg::IW-1:0]    stage,
  input  logic [q2e_pkg::VW-1:0]    rem_in,
  input  logic [q2e_pkg::RW-1:0]    root_in,
  output logic [q2e_pkg::VW-1:0]    rem_out,
  output logic [q2e_pkg::RW-1:0]    root_out
);
  import q2e_pkg::*;

  logic [VW+1:0] trial;
  logic [VW+1:0] rem_ext;

  // (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k)
  assign trial   = ((VW+2)'(root_in) << (stage + 1'b1)) + ((VW+2)'(1) << (2 * stage));
  assign rem_ext = (VW+2)'(rem_in);

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_ext >= trial) begin
        rem_out  <= VW'(rem_ext - trial);
        root_out <= root_in | (RW'(1) << stage);
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in;
      end
    end
  end

endmodule

FILE: rtl/q2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module q2e_cordic_cell (
  input  logic                    clk,
  input  logic                    en,
  input  logic [q2e_pkg::IW-1:0]  stage,
  input  q2e_pkg::rot_t           rot_in,
  output q2e_pkg::rot_t           rot_out
);
  import q2e_pkg::*;

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] at;
  rot_t                 rot_next;

  assign xs = rot_in.x >>> stage;
  assign ys = rot_in.y >>> stage;
  assign at = atan_lut(stage);

  always_comb begin
    rot_next = rot_in;
    if (!rot_in.hold) begin
      if (rot_in.y >= 0) begin
        rot_next.x = rot_in.x + ys;
        rot_next.y = rot_in.y - xs;
        rot_next.z = rot_in.z + at;
      end else begin
        rot_next.x = rot_in.x - ys;
        rot_next.y = rot_in.y + xs;
        rot_next.z = rot_in.z - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) rot_out <= rot_next;
  end

endmodule

FILE: rtl/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined atan2: quadrant / special-case stage, then a chain of cells.
// ----------------------------------------------------------------------------
module q2e_cordic (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [q2e_pkg::MW-1:0]  y_in,
  input  logic signed [q2e_pkg::MW-1:0]  x_in,
  output logic signed [q2e_pkg::ZW-1:0]  angle
);
  import q2e_pkg::*;

  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  rot_t                 pre_next;
  rot_t                 chain [CORDIC_STAGES+1];

  assign xe = CW'(x_in);
  assign ye = CW'(y_in);

  always_comb begin
    pre_next      = '0;
    pre_next.x    = xe;
    pre_next.y    = ye;
    priority if (y_in == 0) begin
      pre_next.hold = 1'b1;
      pre_next.z    = (x_in < 0) ? DEG180 : '0;
    end else if (x_in == 0) begin
      pre_next.hold = 1'b1;
      pre_next.z    = (y_in > 0) ? DEG90 : -DEG90;
    end else if (x_in < 0) begin
      if (y_in >= 0) begin
        pre_next.x = ye;
        pre_next.y = -xe;
        pre_next.z = DEG90;
      end else begin
        pre_next.x = -ye;
        pre_next.y = xe;
        pre_next.z = -DEG90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) chain[0] <= pre_next;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    q2e_cordic_cell u_cell (
      .clk     (clk),
      .en      (en),
      .stage   (IW'(i)),
      .rot_in  (chain[i]),
      .rot_out (chain[i+1])
    );
  end

  assign angle = chain[CORDIC_STAGES].z;

endmodule

FILE: rtl/quaternion_to_euler_yxz_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_yxz_top
// Quaternion (Q1.15) to Y-X-Z Euler angles (yaw, pitch, roll) in Q9.7 deg (pitch Q8.7).
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction can be taken every cycle while the output
// is not stalled. The pipeline depth is set mainly by the 31-cell square-root
// chain feeding the pitch arcsine plus the CORDIC cell chain; yaw and roll
// ride along in delay registers. The whole pipe advances whenever the output
// register is empty or being drained, so quat_ready drops only while a
// finished result sits unclaimed on the output. The quaternion need not be
// normalized; the arcsine argument is clamped to +/-1, atan2(0,0) gives 0
// and atan2(0,-x) gives +180. No configuration, no state between
// transactions.
// ----------------------------------------------------------------------------
module quaternion_to_euler_yxz_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             quat_valid,
  output logic                             quat_ready,
  input  logic signed [q2e_pkg::QW-1:0]    quat_x,
  input  logic signed [q2e_pkg::QW-1:0]    quat_y,
  input  logic signed [q2e_pkg::QW-1:0]    quat_z,
  input  logic signed [q2e_pkg::QW-1:0]    quat_w,
  output logic                             euler_valid,
  input  logic                             euler_ready,
  output logic signed [q2e_pkg::AW-1:0]    yaw_angle,
  output logic signed [q2e_pkg::PAW-1:0]   pitch_angle,
  output logic signed [q2e_pkg::AW-1:0]    roll_angle
);
  import q2e_pkg::*;

  logic           adv;
  logic [LAT-1:0] vld;

  // stage 1: products
  logic signed [PW-1:0] p_xz, p_wy, p_yz, p_wx, p_xy, p_wz, p_xx, p_yy, p_zz;
  // stage 2: matrix terms
  m_terms_t              mt;
  m_terms_t              mt_next;
  m_terms_t              mdl [SQRT_DLY];
  // stages 3-4: s^2, radicand
  logic [VW-1:0]         s_sq;
  logic [VW-1:0]         rad;
  logic [VW-1:0]         sq_rem  [SQRT_BITS+1];
  logic [RW-1:0]         sq_root [SQRT_BITS+1];
  logic signed [2*SW-1:0] s_prod;

  logic signed [ZW-1:0]  yaw_z, pitch_z, roll_z;
  m_terms_t              md;

  // pipe moves unless a result is stuck on the output
  assign adv        = !euler_valid || euler_ready;
  assign quat_ready = adv;
  assign euler_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], quat_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_xz <= quat_x * quat_z;
      p_wy <= quat_w * quat_y;
      p_yz <= quat_y * quat_z;
      p_wx <= quat_w * quat_x;
      p_xy <= quat_x * quat_y;
      p_wz <= quat_w * quat_z;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
    end
  end

  // rotation-matrix terms in 2^-30 units; clamp the arcsine argument
  always_comb begin
    logic signed [MW-1:0] m12;
    mt_next.m02 = (MW'(p_xz) + MW'(p_wy)) <<< 1;
    m12         = (MW'(p_yz) - MW'(p_wx)) <<< 1;
    mt_next.m22 = ONE_Q30 - ((MW'(p_xx) + MW'(p_yy)) <<< 1);
    mt_next.m10 = (MW'(p_xy) + MW'(p_wz)) <<< 1;
    mt_next.m11 = ONE_Q30 - ((MW'(p_xx) + MW'(p_zz)) <<< 1);
    if (m12 > ONE_Q30)       mt_next.s = SW'(ONE_Q30);
    else if (m12 < -ONE_Q30) mt_next.s = SW'(-ONE_Q30);
    else                     mt_next.s = SW'(m12);
  end

  assign s_prod = mt.s * mt.s;

  always_ff @(posedge clk) begin
    if (adv) begin
      mt   <= mt_next;
      s_sq <= VW'(s_prod);
      rad  <= (VW'(1) << 60) - s_sq;
      mdl[0] <= mt;
      for (int i = 1; i < SQRT_DLY; i++) mdl[i] <= mdl[i-1];
    end
  end

  // cos = floor(sqrt(2^60 - s^2)), one root bit per cell, MSB first
  assign sq_rem[0]  = rad;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
    q2e_sqrt_cell u_sqrt (
      .clk      (clk),
      .en       (adv),
      .stage    (IW'(SQRT_BITS - 1 - k)),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1])
    );
  end

  assign md = mdl[SQRT_DLY-1];   // aligned with the final root

  q2e_cordic u_yaw (
    .clk   (clk),
    .en    (adv),
    .y_in  (md.m02),
    .x_in  (md.m22),
    .angle (yaw_z)
  );

  q2e_cordic u_pitch (
    .clk   (clk),
    .en    (adv),
    .y_in  (MW'(md.s)),
    .x_in  (MW'({1'b0, sq_root[SQRT_BITS]})),
    .angle (pitch_z)
  );

  q2e_cordic u_roll (
    .clk   (clk),
    .en    (adv),
    .y_in  (md.m10),
    .x_in  (md.m11),
    .angle (roll_z)
  );

  // output register: round to Q9.7 and saturate; pitch is the negated arcsine
  always_ff @(posedge clk) begin
    if (adv) begin
      yaw_angle   <= round_angle(yaw_z, YAW_LIMIT);
      pitch_angle <= PAW'(round_angle(-pitch_z, PITCH_LIMIT));
      roll_angle  <= round_angle(roll_z, YAW_LIMIT);
    end
  end

endmodule
